/* src/smd_pkg.sv */
// Package for the scaled multiply-divide core: widths, codes and the divider
// stage word. Depends on nothing; every other file of the block imports it.
package smd_pkg;

   // Operand width; the product, limits and divider depth follow from it
   localparam int OPERAND_BITS = 32;
   localparam int PROD_BITS = 2 * OPERAND_BITS;

   // Fixed field widths of the channels
   localparam int KIND_BITS = 2;
   localparam int WIDE_BITS = 32;
   localparam int DEN_BITS = 31;
   localparam int QUOT_BITS = 32;
   localparam int STATUS_BITS = 2;

   // Divider: quotient bits resolved per stage and the number of stages
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = PROD_BITS / STEPS_PER_STAGE;

   // Saturation limits of the rounded quotient, at product width
   localparam logic signed [PROD_BITS-1:0] Q_HIGH =
      (PROD_BITS'(1) << (OPERAND_BITS - 1)) - PROD_BITS'(1);
   localparam logic signed [PROD_BITS-1:0] Q_LOW = ~Q_HIGH;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_FLOOR   = 2'd0,
      KIND_CEIL    = 2'd1,
      KIND_NEAREST = 2'd2
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_IN_RANGE = 2'd0,
      STATUS_SAT_LOW  = 2'd1,
      STATUS_SAT_HIGH = 2'd2
   } status_type;

   // Word carried down the divider chain
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 neg;
      logic                 dz;
      logic [DEN_BITS-1:0]  den;
      logic [DEN_BITS-1:0]  rem;
      logic [PROD_BITS-1:0] work;
   } div_word_type;

endpackage

/* src/smd_if.sv */
// Handshake channels of the scaled multiply-divide core: request and response.
// Depends on smd_pkg for the payload widths.
interface smd_req_if import smd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] kind;
   logic [WIDE_BITS-1:0] operand_a;
   logic [WIDE_BITS-1:0] operand_b;
   logic [DEN_BITS-1:0]  denominator;

   modport source (output valid, kind, operand_a, operand_b, denominator, input ready);
   modport sink (input valid, kind, operand_a, operand_b, denominator, output ready);
endinterface

interface smd_rsp_if import smd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [QUOT_BITS-1:0]   quotient;
   logic [DEN_BITS-1:0]    floor_remainder;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, quotient, floor_remainder, status, input ready);
   modport sink (input valid, quotient, floor_remainder, status, output ready);
endinterface

/* src/smd_div_stage.sv */
// One stage of the pipelined restoring divider: resolves STEPS_PER_STAGE
// quotient bits of the product magnitude. Depends on smd_pkg.
module smd_div_stage import smd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         stage_valid,
   input  div_word_type stage_word,
   output logic         next_valid,
   output div_word_type next_word
);

   logic         valid_ff;
   div_word_type word_ff;
   div_word_type word_in;

   // Shift in one dividend bit, trial-subtract, shift in the quotient bit
   always_comb begin
      div_word_type      w;
      logic [DEN_BITS:0] trial;
      w = stage_word;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         trial = {w.rem, w.work[PROD_BITS-1]};
         if (trial >= {1'b0, w.den}) begin
            w.rem  = DEN_BITS'(trial - {1'b0, w.den});
            w.work = {w.work[PROD_BITS-2:0], 1'b1};
         end else begin
            w.rem  = trial[DEN_BITS-1:0];
            w.work = {w.work[PROD_BITS-2:0], 1'b0};
         end
      end
      word_in = w;
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= stage_valid;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_word  = word_ff;

endmodule

/* src/scaled_mul_div_rounding_core.sv */
// Scaled multiply-divide core: floor, ceiling or nearest quotient of a*b/d.
// Registers from acceptance to the response word: input, product, magnitude,
// 32 divider stages of two bits each, floor fix, round, saturate.
// Throughput: one word per cycle; the whole pipeline advances when the output
// register is empty or taken. Reset (synchronous) clears the valid bits only.
// Depends on smd_pkg, smd_if and smd_div_stage.
module scaled_mul_div_rounding_core import smd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   smd_req_if.sink    req_ch,
   smd_rsp_if.source  rsp_ch
);

   logic enable;

   // Stage 0: input registers
   logic                           valid0_ff;
   logic [KIND_BITS-1:0]           kind0_ff;
   logic signed [OPERAND_BITS-1:0] a0_ff;
   logic signed [OPERAND_BITS-1:0] b0_ff;
   logic [DEN_BITS-1:0]            den0_ff;

   // Stage 1: product
   logic                        valid1_ff;
   logic [KIND_BITS-1:0]        kind1_ff;
   logic [DEN_BITS-1:0]         den1_ff;
   logic signed [PROD_BITS-1:0] prod1_ff;
   logic signed [PROD_BITS-1:0] prod1_in;

   // Stage 2: magnitude and divider head
   logic         valid2_ff;
   div_word_type word2_ff;
   div_word_type word2_in;

   // Divider chain
   logic         chain_valid [DIV_STAGES+1];
   div_word_type chain_word  [DIV_STAGES+1];

   // Stage 3: floor quotient and remainder
   logic                        valid3_ff;
   logic [KIND_BITS-1:0]        kind3_ff;
   logic                        neg3_ff;
   logic                        dz3_ff;
   logic [DEN_BITS-1:0]         den3_ff;
   logic signed [PROD_BITS-1:0] qf3_ff;
   logic [DEN_BITS-1:0]         rf3_ff;
   logic signed [PROD_BITS-1:0] qf3_in;
   logic [DEN_BITS-1:0]         rf3_in;

   // Stage 4: rounded quotient
   logic                        valid4_ff;
   logic                        neg4_ff;
   logic                        dz4_ff;
   logic [DEN_BITS-1:0]         r4_ff;
   logic signed [PROD_BITS-1:0] qr4_ff;
   logic                        inc4_in;

   // Stage 5: output register
   logic                   valid5_ff;
   logic [QUOT_BITS-1:0]   quot5_ff;
   logic [DEN_BITS-1:0]    rem5_ff;
   logic [STATUS_BITS-1:0] status5_ff;
   logic signed [PROD_BITS-1:0] qsat5_in;
   logic [DEN_BITS-1:0]         rem5_in;
   status_type                  status5_in;

   // Whole pipeline moves unless the output word is held
   assign enable       = !valid5_ff || rsp_ch.ready;
   assign req_ch.ready = enable;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (enable) begin
         valid0_ff <= req_ch.valid;
         valid1_ff <= valid0_ff;
         valid2_ff <= valid1_ff;
         valid3_ff <= chain_valid[DIV_STAGES];
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   // Stage 0: take the low operand bits as two's complement
   always_ff @(posedge clock) begin
      if (enable) begin
         kind0_ff <= req_ch.kind;
         a0_ff    <= signed'(req_ch.operand_a[OPERAND_BITS-1:0]);
         b0_ff    <= signed'(req_ch.operand_b[OPERAND_BITS-1:0]);
         den0_ff  <= req_ch.denominator;
      end
   end

   // Stage 1: exact signed product
   assign prod1_in = PROD_BITS'(a0_ff) * PROD_BITS'(b0_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         kind1_ff <= kind0_ff;
         den1_ff  <= den0_ff;
         prod1_ff <= prod1_in;
      end
   end

   // Stage 2: sign and magnitude into the divider word
   always_comb begin
      word2_in.kind = kind1_ff;
      word2_in.neg  = prod1_ff[PROD_BITS-1];
      word2_in.dz   = (den1_ff == '0);
      word2_in.den  = den1_ff;
      word2_in.rem  = '0;
      word2_in.work = prod1_ff[PROD_BITS-1] ? (~prod1_ff + PROD_BITS'(1)) : prod1_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word2_ff <= word2_in;
      end
   end

   assign chain_valid[0] = valid2_ff;
   assign chain_word[0]  = word2_ff;

   // Divider chain, two quotient bits a stage
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      smd_div_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .enable      (enable),
         .stage_valid (chain_valid[s]),
         .stage_word  (chain_word[s]),
         .next_valid  (chain_valid[s+1]),
         .next_word   (chain_word[s+1])
      );
   end

   // Stage 3: turn the magnitude quotient into floor quotient and remainder
   always_comb begin
      div_word_type w;
      w = chain_word[DIV_STAGES];
      if (w.neg && (w.rem != '0)) begin
         qf3_in = ~w.work;
         rf3_in = w.den - w.rem;
      end else if (w.neg) begin
         qf3_in = ~w.work + PROD_BITS'(1);
         rf3_in = '0;
      end else begin
         qf3_in = w.work;
         rf3_in = w.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         kind3_ff <= chain_word[DIV_STAGES].kind;
         neg3_ff  <= chain_word[DIV_STAGES].neg;
         dz3_ff   <= chain_word[DIV_STAGES].dz;
         den3_ff  <= chain_word[DIV_STAGES].den;
         qf3_ff   <= qf3_in;
         rf3_ff   <= rf3_in;
      end
   end

   // Stage 4: rounding increment; unused kind rounds as floor
   always_comb begin
      unique case (kind3_ff)
         KIND_CEIL:    inc4_in = (rf3_ff != '0);
         KIND_NEAREST: inc4_in = ({rf3_ff, 1'b0} >= {1'b0, den3_ff});
         default:      inc4_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg4_ff <= neg3_ff;
         dz4_ff  <= dz3_ff;
         r4_ff   <= rf3_ff;
         qr4_ff  <= qf3_ff + PROD_BITS'(inc4_in);
      end
   end

   // Stage 5: saturate; zero divisor goes to the limit of the product's sign
   always_comb begin
      priority if (dz4_ff && neg4_ff) begin
         qsat5_in   = Q_LOW;
         rem5_in    = '0;
         status5_in = STATUS_SAT_LOW;
      end else if (dz4_ff) begin
         qsat5_in   = Q_HIGH;
         rem5_in    = '0;
         status5_in = STATUS_SAT_HIGH;
      end else if (qr4_ff < Q_LOW) begin
         qsat5_in   = Q_LOW;
         rem5_in    = '0;
         status5_in = STATUS_SAT_LOW;
      end else if (qr4_ff > Q_HIGH) begin
         qsat5_in   = Q_HIGH;
         rem5_in    = '0;
         status5_in = STATUS_SAT_HIGH;
      end else begin
         qsat5_in   = qr4_ff;
         rem5_in    = r4_ff;
         status5_in = STATUS_IN_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot5_ff   <= QUOT_BITS'(signed'(qsat5_in[OPERAND_BITS-1:0]));
         rem5_ff    <= rem5_in;
         status5_ff <= status5_in;
      end
   end

   // Response word
   assign rsp_ch.valid           = valid5_ff;
   assign rsp_ch.quotient        = quot5_ff;
   assign rsp_ch.floor_remainder = rem5_ff;
   assign rsp_ch.status          = status5_ff;

endmodule
